/* design/tdhc_pkg.sv */
// ============================================================================
// Tape head controller package
// Operation codes, register indexes, cell layout constants and the command
// and status groups that pass between the controller and the datapath.
// ============================================================================
package tdhc_pkg;

    // Operation codes of an input item.
    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_DATA_WRITE  = 3'd1;
    localparam logic [2:0] OP_DATA_READ   = 3'd2;
    localparam logic [2:0] OP_STATUS_READ = 3'd3;
    localparam logic [2:0] OP_LOAD_CELL   = 3'd4;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_TAPE_LENGTH    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_PROTECT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_ENABLED  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_NO_WAIT = 4'd3;
    localparam int unsigned CFG_DATA_W = 18;
    localparam logic [CFG_DATA_W-1:0] TAPE_LENGTH_RESET = 18'h20000;

    // Source of the currently held wait.
    localparam logic [1:0] WS_DATA_READ   = 2'd0;
    localparam logic [1:0] WS_STATUS_READ = 2'd1;
    localparam logic [1:0] WS_DATA_WRITE  = 2'd2;

    // Tape cell layout: data byte, data flag, bad flag.
    localparam int unsigned CELL_W       = 10;
    localparam int unsigned DATA_FLAG_B  = 8;
    localparam int unsigned BAD_FLAG_B   = 9;
    localparam logic [8:0]  WRITE_SCRAMBLE = 9'h0EA;
    localparam logic [7:0]  READ_SCRAMBLE  = 8'hCD;

    // Sync detector: oldest bytes first are six zero bytes, then two 0xFF.
    localparam int unsigned SYNC_WINDOW = 8;
    localparam logic [7:0]  SYNC_MARK   = 8'hFF;
    localparam logic [7:0]  HIST_RESET  = 8'hFF;

    // Status byte bits.
    localparam int unsigned ST_GAP_B    = 2;
    localparam int unsigned ST_NOSYNC_B = 1;
    localparam int unsigned ST_NOT_WP_B = 0;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;   // an input item is taken this cycle
        logic finish;   // write-back state of a tick: cell data is back
    } tdhc_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_tick;  // the offered item is a tick
    } tdhc_stat_t;

endpackage

/* design/tdhc_ram.sv */
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module tdhc_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 131072
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/tdhc_ctrl.sv */
// ============================================================================
// Tape head controller sequencer
// Accepts items, steps a tick through its read and write cycles and holds
// the result valid flag.
// ============================================================================
module tdhc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  tdhc_pkg::tdhc_stat_t stat,
    output tdhc_pkg::tdhc_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RMW  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   load_out;

    // An item is taken when idle and the result register is free or draining.
    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign load_out = (accept && !stat.is_tick) || (state_reg == ST_RMW);

    assign cmd.accept = accept;
    assign cmd.finish = (state_reg == ST_RMW);
    assign m_valid    = m_valid_reg;

    // Next state: a tick goes through ST_RMW for the cell write.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && stat.is_tick) begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* design/tdhc_datapath.sv */
// ============================================================================
// Tape head controller datapath
// Tape store, head position, read latch, sync detector, port handshake
// state, configuration registers and the result register.
// ============================================================================
module tdhc_datapath #(
    parameter int unsigned TAPE_DEPTH = 131072
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tdhc_pkg::tdhc_cmd_t                 cmd,
    output tdhc_pkg::tdhc_stat_t                stat,
    input  logic [2:0]                          op,
    input  logic [7:0]                          data_byte,
    input  logic                                head_read,
    input  logic                                erase_only,
    input  logic                                motor_on,
    input  logic [16:0]                         load_address,
    input  logic [9:0]                          load_cell,
    input  logic                                cfg_write,
    input  logic [tdhc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tdhc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [7:0]                          port_data,
    output logic                                wait_asserted,
    output logic                                tape_modified
);

    localparam int unsigned AW = $clog2(TAPE_DEPTH);
    localparam int unsigned WW = ((AW > 17) ? AW : 17) + 1;
    localparam int unsigned LW = ((AW + 1) > 18) ? (AW + 1) : 18;
    localparam int unsigned CW = tdhc_pkg::CELL_W;

    // Configuration registers.
    logic [17:0] tape_length_reg;
    logic        write_protect_reg;
    logic        drive_enabled_reg;
    logic        status_no_wait_reg;

    // Tape and port state.
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] lrw_reg, lrw_next;
    logic [7:0]    pwb_reg, pwb_next;
    logic [7:0]    hist_reg [tdhc_pkg::SYNC_WINDOW];
    logic [7:0]    hist_next [tdhc_pkg::SYNC_WINDOW];
    logic          sync_seen_reg, sync_seen_next;
    logic          wait_flag_reg, wait_flag_next;
    logic [1:0]    wait_src_reg, wait_src_next;
    logic          read_pend_reg, read_pend_next;
    logic          stat_pend_reg, stat_pend_next;

    // Tick controls held over the memory read.
    logic tick_rd_reg, tick_erase_reg, tick_motor_reg;

    // Result register.
    logic [7:0] port_reg, port_next;
    logic       wait_out_reg, wait_out_next;
    logic       mod_reg, mod_next;
    logic       load_out;

    // Memory interface.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [CW-1:0] ram_wdata;
    logic [CW-1:0] ram_rdata;
    logic          ram_re;

    logic [WW-1:0] load_wide;
    logic [AW-1:0] load_idx;
    logic          load_in_range;
    logic [LW-1:0] len_clamped;
    logic [LW-1:0] head_inc;
    logic [AW-1:0] head_adv;
    logic [7:0]    status_now;
    logic [8:0]    wr_low;
    logic [CW-1:0] word;
    logic          sync_hit;

    assign stat.is_tick = (op == tdhc_pkg::OP_TICK);
    assign load_out     = (cmd.accept && !stat.is_tick) || cmd.finish;

    // Load address range check and index.
    assign load_wide     = WW'(load_address);
    assign load_idx      = load_wide[AW-1:0];
    assign load_in_range = (load_wide < WW'(TAPE_DEPTH));

    // Head advance with the loop length clamped to the store depth.
    assign len_clamped = (LW'(tape_length_reg) > LW'(TAPE_DEPTH)) ? LW'(TAPE_DEPTH)
                                                                  : LW'(tape_length_reg);
    assign head_inc    = LW'(head_reg) + LW'(1);
    assign head_adv    = (head_inc >= len_clamped) ? '0 : head_inc[AW-1:0];

    // Status byte as seen with the motor given on the current item.
    always_comb begin
        status_now = '0;
        if (motor_on) begin
            if (!lrw_reg[tdhc_pkg::DATA_FLAG_B]) begin
                status_now[tdhc_pkg::ST_GAP_B] = 1'b1;
            end else if (!sync_seen_reg) begin
                status_now[tdhc_pkg::ST_NOSYNC_B] = 1'b1;
            end
            status_now[tdhc_pkg::ST_NOT_WP_B] = !write_protect_reg;
        end
    end

    // Cell written by the head in write mode; the bad flag stays put.
    always_comb begin
        wr_low = tick_erase_reg ? 9'h000 : {1'b1, pwb_reg};
        if (ram_rdata[tdhc_pkg::BAD_FLAG_B]) begin
            wr_low = wr_low ^ tdhc_pkg::WRITE_SCRAMBLE;
        end
    end

    // Word latched in read mode: the cell under the head or the old latch.
    assign word = tick_motor_reg ? ram_rdata : lrw_reg;

    // Sync pattern check on the history after this shift.
    always_comb begin
        sync_hit = (word[7:0] == tdhc_pkg::SYNC_MARK) && (hist_reg[0] == tdhc_pkg::SYNC_MARK);
        for (int i = 1; i < tdhc_pkg::SYNC_WINDOW - 1; i++) begin
            if (hist_reg[i] != 8'h00) begin
                sync_hit = 1'b0;
            end
        end
    end

    // Memory port selection.
    assign ram_re    = cmd.accept && stat.is_tick;
    assign ram_we    = (cmd.accept && (op == tdhc_pkg::OP_LOAD_CELL) && load_in_range)
                    || (cmd.finish && !tick_rd_reg && tick_motor_reg && drive_enabled_reg);
    assign ram_waddr = cmd.finish ? head_reg : load_idx;
    assign ram_wdata = cmd.finish ? {ram_rdata[tdhc_pkg::BAD_FLAG_B], wr_low} : load_cell;

    // Item processing.
    always_comb begin
        head_next      = head_reg;
        lrw_next       = lrw_reg;
        pwb_next       = pwb_reg;
        for (int i = 0; i < tdhc_pkg::SYNC_WINDOW; i++) begin
            hist_next[i] = hist_reg[i];
        end
        sync_seen_next = sync_seen_reg;
        wait_flag_next = wait_flag_reg;
        wait_src_next  = wait_src_reg;
        read_pend_next = read_pend_reg;
        stat_pend_next = stat_pend_reg;
        port_next      = 8'h00;
        mod_next       = 1'b0;

        if (cmd.finish) begin
            // Tick: release a held wait and make a held read's answer ready.
            if (wait_flag_reg) begin
                if (wait_src_reg == tdhc_pkg::WS_STATUS_READ) begin
                    stat_pend_next = 1'b1;
                end
                if (wait_src_reg == tdhc_pkg::WS_DATA_READ) begin
                    read_pend_next = 1'b1;
                end
            end
            wait_flag_next = 1'b0;

            if (!tick_rd_reg) begin
                mod_next = tick_motor_reg && drive_enabled_reg;
            end else if (tick_erase_reg) begin
                hist_next[0] = word[7:0];
                for (int i = 1; i < tdhc_pkg::SYNC_WINDOW; i++) begin
                    hist_next[i] = hist_reg[i-1];
                end
                if (!word[tdhc_pkg::DATA_FLAG_B]) begin
                    lrw_next       = '0;
                    sync_seen_next = 1'b0;
                end else begin
                    lrw_next = word;
                    if (sync_hit) begin
                        sync_seen_next = 1'b1;
                    end
                    if (word[tdhc_pkg::BAD_FLAG_B]) begin
                        lrw_next[7:0] = word[7:0] ^ tdhc_pkg::READ_SCRAMBLE;
                    end
                end
            end

            if (tick_motor_reg) begin
                head_next = head_adv;
            end
        end else if (cmd.accept) begin
            case (op)
                tdhc_pkg::OP_DATA_WRITE: begin
                    pwb_next       = data_byte;
                    wait_flag_next = 1'b1;
                    wait_src_next  = tdhc_pkg::WS_DATA_WRITE;
                end
                tdhc_pkg::OP_DATA_READ: begin
                    if (read_pend_reg) begin
                        read_pend_next = 1'b0;
                        port_next = lrw_reg[tdhc_pkg::DATA_FLAG_B] ? lrw_reg[7:0] : 8'h00;
                    end else begin
                        wait_src_next  = tdhc_pkg::WS_DATA_READ;
                        wait_flag_next = 1'b1;
                    end
                end
                tdhc_pkg::OP_STATUS_READ: begin
                    if (status_no_wait_reg) begin
                        port_next = status_now;
                    end else if (stat_pend_reg) begin
                        stat_pend_next = 1'b0;
                        port_next      = status_now;
                    end else begin
                        wait_flag_next = 1'b1;
                        wait_src_next  = tdhc_pkg::WS_STATUS_READ;
                    end
                end
                tdhc_pkg::OP_LOAD_CELL: begin
                    mod_next = load_in_range;
                end
                default: begin
                end
            endcase
        end
    end

    assign wait_out_next = wait_flag_next;

    // Tape store.
    tdhc_ram #(
        .WIDTH (CW),
        .DEPTH (TAPE_DEPTH)
    ) u_tape (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tape_length_reg    <= tdhc_pkg::TAPE_LENGTH_RESET;
            write_protect_reg  <= 1'b0;
            drive_enabled_reg  <= 1'b0;
            status_no_wait_reg <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_index)
                tdhc_pkg::REG_TAPE_LENGTH:    tape_length_reg    <= cfg_data;
                tdhc_pkg::REG_WRITE_PROTECT:  write_protect_reg  <= cfg_data[0];
                tdhc_pkg::REG_DRIVE_ENABLED:  drive_enabled_reg  <= cfg_data[0];
                tdhc_pkg::REG_STATUS_NO_WAIT: status_no_wait_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Tape and port state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            lrw_reg       <= '0;
            pwb_reg       <= '0;
            for (int i = 0; i < tdhc_pkg::SYNC_WINDOW; i++) begin
                hist_reg[i] <= tdhc_pkg::HIST_RESET;
            end
            sync_seen_reg <= 1'b0;
            wait_flag_reg <= 1'b0;
            wait_src_reg  <= tdhc_pkg::WS_DATA_READ;
            read_pend_reg <= 1'b0;
            stat_pend_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            lrw_reg       <= lrw_next;
            pwb_reg       <= pwb_next;
            for (int i = 0; i < tdhc_pkg::SYNC_WINDOW; i++) begin
                hist_reg[i] <= hist_next[i];
            end
            sync_seen_reg <= sync_seen_next;
            wait_flag_reg <= wait_flag_next;
            wait_src_reg  <= wait_src_next;
            read_pend_reg <= read_pend_next;
            stat_pend_reg <= stat_pend_next;
        end
    end

    // Tick controls and result payload.
    always_ff @(posedge aclk) begin
        if (cmd.accept && stat.is_tick) begin
            tick_rd_reg    <= head_read;
            tick_erase_reg <= erase_only;
            tick_motor_reg <= motor_on;
        end
        if (load_out) begin
            port_reg     <= port_next;
            wait_out_reg <= wait_out_next;
            mod_reg      <= mod_next;
        end
    end

    assign port_data     = port_reg;
    assign wait_asserted = wait_out_reg;
    assign tape_modified = mod_reg;

endmodule

/* design/tape_drive_head_controller_unit.sv */
// ============================================================================
// Tape drive head controller
// Looped tape store with a read/write head, sync detection and a data and
// status port that hold wait until the next head tick; status no-wait lets status reads answer at once.
// ============================================================================
//
//  Channel   Direction  Handshake              Contents
//  s_        in         s_valid / s_ready      op, data byte, head controls, load
//  m_        out        m_valid / m_ready      port byte, wait, tape modified
//  cfg_      in         cfg_valid / cfg_ready  register index and write data
//
// A tick reads the cell under the head from the tape RAM in the accept cycle
// and, in write mode, writes it back in the next. All other items finish in
// the accept cycle. Each item yields one result in the output register, and a
// new item is taken while that result is being handed off. Reset is
// synchronous; the tape RAM is not cleared by reset.
// Configuration writes are taken in every cycle.
module tape_drive_head_controller_unit #(
    parameter int unsigned TAPE_DEPTH = 131072
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [2:0]                      s_op,
    input  logic [7:0]                      s_data_byte,
    input  logic                            s_head_read,
    input  logic                            s_erase_only,
    input  logic                            s_motor_on,
    input  logic [16:0]                     s_load_address,
    input  logic [9:0]                      s_load_cell,
    // Result items
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_port_data,
    output logic                            m_wait_asserted,
    output logic                            m_tape_modified,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tdhc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tdhc_pkg::CFG_DATA_W-1:0] cfg_data
);

    tdhc_pkg::tdhc_cmd_t  cmd;
    tdhc_pkg::tdhc_stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer.
    tdhc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Tape, head and port state.
    tdhc_datapath #(
        .TAPE_DEPTH (TAPE_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .op            (s_op),
        .data_byte     (s_data_byte),
        .head_read     (s_head_read),
        .erase_only    (s_erase_only),
        .motor_on      (s_motor_on),
        .load_address  (s_load_address),
        .load_cell     (s_load_cell),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .port_data     (m_port_data),
        .wait_asserted (m_wait_asserted),
        .tape_modified (m_tape_modified)
    );

    // No item is taken while a tick is writing its cell back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !s_ready)
        else $error("item accepted during tick write-back");

    // An accepted tick finishes in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && stat.is_tick) |=> cmd.finish)
        else $error("tick did not reach write-back");

    // A finished tick presents its result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid)
        else $error("tick result missing");

    // A tick always releases wait.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> !m_wait_asserted)
        else $error("wait still held after tick");

endmodule
